[src/assert_macros.svh]
// assertion macros shared by the bitmap rtl
// no dependencies; synthesis builds define SYNTH to drop the checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WICB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed");
`define WICB_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");
`else
`define WICB_ASSERT(label, clk, rst, prop)
`define WICB_NEVER(label, clk, rst, cond)
`endif
`endif

[src/wicb_pkg.sv]
// shared constants, types and helper functions of the write-intent bitmap
// no dependencies
`timescale 1ns / 1ps
package wicb_pkg;
   localparam int WORD_W      = 64;
   localparam int PAGE_WORDS  = 512;
   localparam int NUM_PAGES   = 32;
   localparam int TOTAL_WORDS = PAGE_WORDS * NUM_PAGES;
   localparam int PWORD_W     = $clog2(PAGE_WORDS);
   localparam int PAGE_W      = $clog2(NUM_PAGES);
   localparam int WADDR_W     = PWORD_W + PAGE_W;
   localparam int CHUNK_W     = WADDR_W + 6;
   localparam int PAGE_SHIFT  = PWORD_W + 6;
   localparam int ADDR_W      = 44;
   localparam int LEN_W       = 44;
   localparam int SHIFT_W     = 5;
   localparam int CNT_W       = CHUNK_W + 1;
   localparam int NZW_W       = PWORD_W + 1;
   localparam int RUNB_W      = 31;
   localparam int DONE_W      = 40;
   localparam int EST_W       = 45;
   localparam int PIU_W       = 6;

   localparam logic [2:0] REQ_MARK  = 3'd0;
   localparam logic [2:0] REQ_CLEAN = 3'd1;
   localparam logic [2:0] REQ_TEST  = 3'd2;
   localparam logic [2:0] REQ_FIND  = 3'd3;
   localparam logic [2:0] REQ_DROP  = 3'd4;

   localparam logic CSR_SHIFT = 1'b0;
   localparam logic CSR_DSIZE = 1'b1;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [ADDR_W-1:0] start_addr;
      logic [LEN_W-1:0]  range_len;
   } wicb_req_type;

   typedef struct packed {
      logic [PIU_W-1:0]  pages_in_use;
      logic [EST_W-1:0]  dirty_bytes_est;
      logic              page_all_clear;
      logic [4:0]        page_index;
      logic [DONE_W-1:0] bytes_done;
      logic [RUNB_W-1:0] run_bytes;
      logic [ADDR_W-1:0] run_addr;
      logic              any_dirty;
   } wicb_rsp_type;

   typedef struct packed {
      logic               we;
      logic [WADDR_W-1:0] waddr;
      logic [WORD_W-1:0]  wdata;
      logic [WADDR_W-1:0] raddr;
   } wicb_mem_type;

   typedef struct packed {
      logic ready;
      logic done;
   } wicb_stat_type;

   function automatic logic [6:0] popcnt64(input logic [63:0] x);
      logic [63:0] a, b, c, d, e, f;
      a = x - ((x >> 1) & 64'h5555555555555555);
      b = (a & 64'h3333333333333333) + ((a >> 2) & 64'h3333333333333333);
      c = (b + (b >> 4)) & 64'h0f0f0f0f0f0f0f0f;
      d = c + (c >> 8);
      e = d + (d >> 16);
      f = e + (e >> 32);
      return f[6:0];
   endfunction

   // chunks [a, b) of a word, lowest chunk in the msb
   function automatic logic [63:0] span_mask(input logic [5:0] a, input logic [6:0] b);
      logic [63:0] hi, lo;
      hi = {64{1'b1}} >> a;
      lo = b[6] ? 64'd0 : ({64{1'b1}} >> b[5:0]);
      return hi & ~lo;
   endfunction
endpackage

[src/write_intent_chunk_bitmap_top.sv]
// mark/clean/test: SET1, SET2, RD/MOD/CNT per word touched, then FIN; a present-page clean adds PCLR
// find: FRD per absent page, FRD/FCHK per present word scanned, FBIT bit scan, then FC1, FC2, FIN
// drop: DROP then FIN; next accept in the cycle after the result; one request in flight
// the result register lets the next request start while a result waits
// synchronous reset clears flags and count, then sweeps the 16384-word store
// with req_tready low; csr writes are taken throughout
`timescale 1ns / 1ps
`include "assert_macros.svh"
module write_intent_chunk_bitmap_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // start_addr, range_len
   input  logic [2:0]   req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // any_dirty, run_addr, run_bytes, bytes_done, page_index, page_all_clear,
   // dirty_bytes_est, pages_in_use
   output logic [175:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   import wicb_pkg::*;

   logic [SHIFT_W-1:0] shift_ff;
   logic [ADDR_W-1:0]  dsize_ff;
   logic               rsp_valid_ff;
   wicb_rsp_type       rsp_ff;
   wicb_req_type       req;
   wicb_rsp_type       eng_rsp;
   wicb_mem_type       mem;
   wicb_stat_type      stat;
   logic [63:0]        rdata;
   logic               out_free, req_go, csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[3] == CSR_DSIZE) ? 64'(dsize_ff) : 64'(shift_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_W'(15);
         dsize_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[3] == CSR_SHIFT) shift_ff <= csr_pwdata[SHIFT_W-1:0];
         else dsize_ff <= csr_pwdata[ADDR_W-1:0];
      end
   end

   assign req.req_type   = req_tuser;
   assign req.start_addr = req_tdata[43:0];
   assign req.range_len  = req_tdata[87:44];
   assign req_tready     = stat.ready;
   assign req_go         = req_tvalid && req_tready;
   assign out_free       = !rsp_valid_ff || rsp_tready;

   wicb_ram u_ram (
      .clock (clock),
      .mem   (mem),
      .rdata (rdata)
   );

   wicb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_go    (req_go),
      .req       (req),
      .cfg_shift (shift_ff),
      .cfg_dsize (dsize_ff),
      .out_free  (out_free),
      .rdata     (rdata),
      .mem       (mem),
      .rsp       (eng_rsp),
      .stat      (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) rsp_ff <= eng_rsp;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, rsp_ff};

   `WICB_ASSERT(a_done_slot_free, clock, reset, stat.done |-> out_free)
   `WICB_ASSERT(a_busy_after_accept, clock, reset, req_go |=> !req_tready)
   `WICB_ASSERT(a_done_shows_beat, clock, reset, stat.done |=> rsp_tvalid)
   `WICB_NEVER(a_no_accept_on_done, clock, reset, req_go && stat.done)
endmodule

[src/wicb_ram.sv]
// bitmap word store, one write port and one registered read port
// depends on wicb_pkg
`timescale 1ns / 1ps
module wicb_ram (
   input  logic                  clock,
   input  wicb_pkg::wicb_mem_type mem,
   output logic [63:0]           rdata
);
   import wicb_pkg::*;

   logic [WORD_W-1:0] store [TOTAL_WORDS];

   always_ff @(posedge clock) begin
      if (mem.we) begin
         store[mem.waddr] <= mem.wdata;
      end
      rdata <= store[mem.raddr];
   end
endmodule

[src/wicb_engine.sv]
// request sequencer: range setup, word read-modify-write, run scan, page drop
// depends on wicb_pkg; drives the word store through a wicb_mem_type struct
`timescale 1ns / 1ps
module wicb_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_go,
   input  wicb_pkg::wicb_req_type   req,
   input  logic [4:0]               cfg_shift,
   input  logic [43:0]              cfg_dsize,
   input  logic                     out_free,
   input  logic [63:0]              rdata,
   output wicb_pkg::wicb_mem_type   mem,
   output wicb_pkg::wicb_rsp_type   rsp,
   output wicb_pkg::wicb_stat_type  stat
);
   import wicb_pkg::*;

   typedef enum logic [14:0] {
      ST_CLR   = 15'h0001,
      ST_IDLE  = 15'h0002,
      ST_SET1  = 15'h0004,
      ST_SET2  = 15'h0008,
      ST_RD    = 15'h0010,
      ST_MOD   = 15'h0020,
      ST_CNT   = 15'h0040,
      ST_PCLR  = 15'h0080,
      ST_FRD   = 15'h0100,
      ST_FCHK  = 15'h0200,
      ST_FBIT  = 15'h0400,
      ST_FC1   = 15'h0800,
      ST_FC2   = 15'h1000,
      ST_DROP  = 15'h2000,
      ST_FIN   = 15'h4000
   } state_type;

   state_type            state_ff, state_in;
   logic [2:0]           op_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [LEN_W-1:0]     len_ff;
   logic [SHIFT_W-1:0]   sh_ff;
   logic [ADDR_W-1:0]    ds_ff;
   logic                 pok_ff;
   logic [CHUNK_W-1:0]   lo_ff;
   logic [CHUNK_W:0]     hi_ff;
   logic [WADDR_W-1:0]   w_ff;
   logic [63:0]          delta_ff;
   logic [63:0]          sv_ff;
   logic [5:0]           lead_ff;
   logic [6:0]           run_ff;
   logic                 phase_ff;
   logic [50:0]          off_ff;
   logic [37:0]          rb_ff;
   logic                 any_ff;
   logic [ADDR_W-1:0]    raddr_ff;
   logic [RUNB_W-1:0]    rbytes_ff;
   logic [DONE_W-1:0]    done_ff;
   logic [4:0]           pidx_ff;
   logic                 pclr_ff;
   logic [CNT_W-1:0]     dirty_ff;
   logic [NUM_PAGES-1:0] present_ff;
   logic [NZW_W-1:0]     nzw_ff [NUM_PAGES];

   // range setup
   logic [5:0]        shp;
   logic [ADDR_W-1:0] page_full;
   logic [46:0]       pw, off, rem;
   logic [LEN_W-1:0]  sz;
   logic [45:0]       csz, endb, hi_raw;
   logic [CHUNK_W:0]  hi_c;
   logic [ADDR_W-1:0] lo_full;
   logic              go;
   // word step
   logic [CHUNK_W:0]   hm1;
   logic [WADDR_W-1:0] lo_w, hi_w;
   logic [5:0]         ma;
   logic [6:0]         mb;
   logic [63:0]        m, nw;
   logic [PAGE_W-1:0]  wpg;
   logic [6:0]         n;
   logic [CNT_W-1:0]   full;
   logic [51:0]        endr;
   logic [ADDR_W-1:0]  rbc;
   logic [6:0]         piu;

   always_comb begin
      shp       = 6'(sh_ff) + 6'd15;
      page_full = addr_ff >> shp;
      pw        = 47'd1 << shp;
      off       = {3'b0, addr_ff} & (pw - 47'd1);
      rem       = pw - off;
      sz        = ({3'b0, len_ff} < rem) ? len_ff : rem[LEN_W-1:0];
      csz       = 46'd1 << sh_ff;
      endb      = {2'b0, addr_ff} + {2'b0, len_ff} + csz - 46'd1;
      hi_raw    = endb >> sh_ff;
      hi_c      = (hi_raw > 46'(TOTAL_WORDS * 64)) ? (CHUNK_W+1)'(TOTAL_WORDS * 64)
                                                   : hi_raw[CHUNK_W:0];
      lo_full   = addr_ff >> sh_ff;
      go        = (lo_full < {{(ADDR_W-CHUNK_W-1){1'b0}}, hi_c}) &&
                  ((op_ff == REQ_CLEAN) ? pok_ff : (len_ff != '0));
      hm1       = hi_ff - 1'b1;
      lo_w      = lo_ff[CHUNK_W-1:6];
      hi_w      = hm1[CHUNK_W-1:6];
      ma        = (w_ff == lo_w) ? lo_ff[5:0] : 6'd0;
      mb        = (w_ff == hi_w) ? ({1'b0, hm1[5:0]} + 7'd1) : 7'd64;
      m         = span_mask(ma, mb);
      nw        = (op_ff == REQ_MARK) ? (rdata | m) : (rdata & ~m);
      wpg       = w_ff[WADDR_W-1:PWORD_W];
      n         = popcnt64(delta_ff);
      full      = CNT_W'(popcnt64(64'(present_ff))) << PAGE_SHIFT;
      endr      = {1'b0, off_ff} + 52'(rb_ff);
      if (endr > 52'(ds_ff)) begin
         rbc = (off_ff >= 51'(ds_ff)) ? '0 : ds_ff - off_ff[ADDR_W-1:0];
      end else begin
         rbc = rb_ff[ADDR_W-1:0];
      end
      piu       = popcnt64(64'(present_ff));
   end

   always_comb begin
      mem.raddr = w_ff;
      mem.waddr = w_ff;
      mem.we    = (state_ff == ST_CLR) ||
                  ((state_ff == ST_MOD) && (op_ff != REQ_TEST));
      mem.wdata = (state_ff == ST_CLR) ? 64'd0 : nw;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR:  if (w_ff == WADDR_W'(TOTAL_WORDS - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req_go) begin
            case (req.req_type)
               REQ_MARK, REQ_CLEAN, REQ_TEST: state_in = ST_SET1;
               REQ_FIND: state_in = ST_FRD;
               REQ_DROP: state_in = ST_DROP;
               default:  state_in = ST_FIN;
            endcase
         end
         ST_SET1: state_in = ST_SET2;
         ST_SET2: begin
            if (go) state_in = ST_RD;
            else if (op_ff == REQ_CLEAN && pok_ff) state_in = ST_PCLR;
            else state_in = ST_FIN;
         end
         ST_RD:  state_in = ST_MOD;
         ST_MOD: state_in = ST_CNT;
         ST_CNT: begin
            if (w_ff != hi_w) state_in = ST_RD;
            else if (op_ff == REQ_CLEAN) state_in = ST_PCLR;
            else state_in = ST_FIN;
         end
         ST_PCLR: state_in = ST_FIN;
         ST_FRD: begin
            if (present_ff[wpg]) state_in = ST_FCHK;
            else if (wpg == PAGE_W'(NUM_PAGES - 1)) state_in = ST_FIN;
         end
         ST_FCHK: begin
            if (rdata != '0) state_in = ST_FBIT;
            else if (w_ff == WADDR_W'(TOTAL_WORDS - 1)) state_in = ST_FIN;
            else state_in = ST_FRD;
         end
         ST_FBIT: if (phase_ff && !sv_ff[63]) state_in = ST_FC1;
         ST_FC1:  state_in = ST_FC2;
         ST_FC2:  state_in = ST_FIN;
         ST_DROP: state_in = ST_FIN;
         ST_FIN:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         w_ff       <= '0;
         dirty_ff   <= '0;
         present_ff <= '0;
         for (int p = 0; p < NUM_PAGES; p++) nzw_ff[p] <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_CLR: w_ff <= w_ff + 1'b1;
            ST_IDLE: if (req_go) begin
               op_ff     <= req.req_type;
               addr_ff   <= req.start_addr;
               len_ff    <= req.range_len;
               sh_ff     <= cfg_shift;
               ds_ff     <= cfg_dsize;
               any_ff    <= 1'b0;
               raddr_ff  <= '0;
               rbytes_ff <= '0;
               done_ff   <= '0;
               pidx_ff   <= '0;
               pclr_ff   <= 1'b0;
               w_ff      <= '0;
            end
            ST_SET1: if (op_ff == REQ_CLEAN) begin
               len_ff  <= sz;
               done_ff <= sz[DONE_W-1:0];
               pidx_ff <= page_full[4:0];
               pok_ff  <= (page_full < ADDR_W'(NUM_PAGES)) &&
                          present_ff[page_full[PAGE_W-1:0]];
            end
            ST_SET2: begin
               lo_ff <= lo_full[CHUNK_W-1:0];
               hi_ff <= hi_c;
               w_ff  <= lo_full[CHUNK_W-1:6];
            end
            ST_MOD: begin
               case (op_ff)
                  REQ_MARK: begin
                     delta_ff        <= m & ~rdata;
                     present_ff[wpg] <= 1'b1;
                  end
                  REQ_CLEAN: delta_ff <= rdata & m;
                  default: begin
                     delta_ff <= '0;
                     if ((rdata & m) != '0) any_ff <= 1'b1;
                  end
               endcase
               if (op_ff != REQ_TEST) begin
                  nzw_ff[wpg] <= nzw_ff[wpg] + NZW_W'(nw != '0) - NZW_W'(rdata != '0);
               end
            end
            ST_CNT: begin
               if (op_ff == REQ_MARK) dirty_ff <= dirty_ff + CNT_W'(n);
               else if (dirty_ff > CNT_W'(n)) dirty_ff <= dirty_ff - CNT_W'(n);
               else dirty_ff <= '0;
               w_ff <= w_ff + 1'b1;
            end
            ST_PCLR: pclr_ff <= (nzw_ff[pidx_ff[PAGE_W-1:0]] == '0);
            ST_FRD: if (!present_ff[wpg] && wpg != PAGE_W'(NUM_PAGES - 1)) begin
               // absent pages hold no dirty bits
               w_ff <= {wpg + 1'b1, {PWORD_W{1'b0}}};
            end
            ST_FCHK: begin
               sv_ff    <= rdata;
               lead_ff  <= '0;
               run_ff   <= '0;
               phase_ff <= 1'b0;
               if (rdata == '0) w_ff <= w_ff + 1'b1;
            end
            ST_FBIT: begin
               if (!phase_ff) begin
                  if (sv_ff[63]) phase_ff <= 1'b1;
                  else begin
                     sv_ff   <= sv_ff << 1;
                     lead_ff <= lead_ff + 1'b1;
                  end
               end else if (sv_ff[63]) begin
                  sv_ff  <= sv_ff << 1;
                  run_ff <= run_ff + 1'b1;
               end
            end
            ST_FC1: begin
               off_ff <= 51'({w_ff, lead_ff}) << sh_ff;
               rb_ff  <= 38'(run_ff) << sh_ff;
            end
            ST_FC2: begin
               raddr_ff  <= off_ff[ADDR_W-1:0];
               rbytes_ff <= (rbc > ADDR_W'({RUNB_W{1'b1}})) ? {RUNB_W{1'b1}}
                                                            : rbc[RUNB_W-1:0];
            end
            ST_DROP: begin
               for (int p = 0; p < NUM_PAGES; p++) begin
                  if (nzw_ff[p] == '0) present_ff[p] <= 1'b0;
               end
            end
            ST_FIN: begin
               // drop leaves the count capped by the surviving pages
               if (op_ff == REQ_DROP && dirty_ff > full) dirty_ff <= full;
            end
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0] dirty_now;
   logic [51:0]      est_now;
   always_comb begin
      dirty_now = (op_ff == REQ_DROP && dirty_ff > full) ? full : dirty_ff;
      est_now   = 52'(dirty_now) << sh_ff;
   end

   always_comb begin
      rsp.any_dirty       = any_ff;
      rsp.run_addr        = raddr_ff;
      rsp.run_bytes       = rbytes_ff;
      rsp.bytes_done      = done_ff;
      rsp.page_index      = pidx_ff;
      rsp.page_all_clear  = pclr_ff;
      rsp.dirty_bytes_est = (est_now > 52'({EST_W{1'b1}})) ? {EST_W{1'b1}}
                                                           : est_now[EST_W-1:0];
      rsp.pages_in_use    = piu[PIU_W-1:0];
      stat.ready          = (state_ff == ST_IDLE);
      stat.done           = (state_ff == ST_FIN) && out_free;
   end
endmodule
